FILE: rtl/ffa_pkg.sv
package ffa_pkg;

  localparam int unsigned DATA_W = 16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_NULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  // one request as taken from the input channel
  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] offset;
  } req_t;

  // one result handed to the output stage
  typedef struct packed {
    logic [DATA_W-1:0] payload;
    status_t           status;
  } res_t;

endpackage

FILE: rtl/ffa_ram.sv
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/ffa_slot_map.sv
module ffa_slot_map #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic                     wr_val,
  input  logic [$clog2(SLOTS)-1:0] wr_idx,
  input  logic [$clog2(SLOTS)-1:0] rd_idx,
  output logic                     rd_bit
);

  logic [SLOTS-1:0] used_r;
  logic [SLOTS-1:0] used_nxt;

  // occupancy bits, slot 0 always holds the list head
  always_comb begin
    used_nxt = used_r;
    if (wr_en) begin
      used_nxt[wr_idx] = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= SLOTS'(1);
    end else begin
      used_r <= used_nxt;
    end
  end

  assign rd_bit = used_r[rd_idx];

endmodule

FILE: rtl/ffa_engine.sv
module ffa_engine
  import ffa_pkg::*;
#(
  parameter int unsigned HEAP_BYTES      = 65536,
  parameter int unsigned HEADER_BYTES    = 12,
  parameter int unsigned MIN_SPLIT_BYTES = 16,
  parameter int unsigned MAX_SEGMENTS    = 64,
  localparam int unsigned LINK_W         = $clog2(MAX_SEGMENTS),
  localparam int unsigned REC_W          = 2 * DATA_W + 1 + LINK_W
) (
  input  logic              clk,
  input  logic              rst_n,
  // request side
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  // result side
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  // segment table memory
  output logic              ram_wr_en,
  output logic [LINK_W-1:0] ram_wr_addr,
  output logic [REC_W-1:0]  ram_wr_data,
  output logic              ram_rd_en,
  output logic [LINK_W-1:0] ram_rd_addr,
  input  logic [REC_W-1:0]  ram_rd_data,
  // slot occupancy map
  output logic              slot_wr_en,
  output logic              slot_wr_val,
  output logic [LINK_W-1:0] slot_wr_idx,
  output logic [LINK_W-1:0] slot_rd_idx,
  input  logic              slot_rd_bit
);

  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] bytes;
    logic              free;
    logic [LINK_W-1:0] link;
  } rec_t;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_A_WALK   = 8'b0000_0010,
    S_A_SCAN   = 8'b0000_0100,
    S_A_SPLIT  = 8'b0000_1000,
    S_A_SPLIT2 = 8'b0001_0000,
    S_R_FIND   = 8'b0010_0000,
    S_R_MERGE  = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  localparam logic [DATA_W-1:0] HDR      = DATA_W'(HEADER_BYTES);
  localparam logic [LINK_W-1:0] IDX_LAST = LINK_W'(MAX_SEGMENTS - 1);
  localparam logic [LINK_W-1:0] IDX_HEAD = '0;
  localparam logic [LINK_W-1:0] IDX_ONE  = LINK_W'(1);
  localparam rec_t HEAD_REC = '{
    start: '0,
    bytes: DATA_W'(HEAP_BYTES - HEADER_BYTES),
    free:  1'b1,
    link:  '0
  };

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] size_r, size_nxt;
  logic [DATA_W-1:0] offset_r, offset_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  rec_t              cur_rec_r, cur_rec_nxt;
  logic [LINK_W-1:0] prev_r, prev_nxt;
  rec_t              prev_rec_r, prev_rec_nxt;
  logic              has_prev_r, has_prev_nxt;
  logic [LINK_W-1:0] steps_r, steps_nxt;
  logic [LINK_W-1:0] scan_r, scan_nxt;
  res_t              res_r, res_nxt;
  logic              head_fresh_r, head_fresh_nxt;
  logic              rd_fresh_r, rd_fresh_nxt;

  rec_t              rd_rec;
  rec_t              wr_rec;
  rec_t              merge_rec;
  logic [LINK_W-1:0] merge_idx;
  logic              fit;
  logic              split_need;
  logic              hit;
  logic              walk_end;

  // head entry reads as its reset value until first written
  assign rd_rec = rd_fresh_r ? HEAD_REC : rec_t'(ram_rd_data);

  // per-entry checks on the record just read
  assign fit        = rd_rec.free && (rd_rec.bytes >= size_r);
  assign split_need = {2'b00, rd_rec.bytes} >
                      ({2'b00, size_r} + 18'(HEADER_BYTES + MIN_SPLIT_BYTES));
  assign hit        = ({1'b0, rd_rec.start} + 17'(HEADER_BYTES)) == {1'b0, offset_r};
  assign walk_end   = (rd_rec.link == IDX_HEAD) || (steps_r == IDX_LAST);

  assign req_ready   = (state_r == S_IDLE);
  assign res         = res_r;
  assign ram_wr_data = wr_rec;
  assign slot_rd_idx = scan_r;

  // sequencer: walk, scan for a spare slot, split or merge, write back
  always_comb begin
    state_nxt      = state_r;
    size_nxt       = size_r;
    offset_nxt     = offset_r;
    cur_nxt        = cur_r;
    cur_rec_nxt    = cur_rec_r;
    prev_nxt       = prev_r;
    prev_rec_nxt   = prev_rec_r;
    has_prev_nxt   = has_prev_r;
    steps_nxt      = steps_r;
    scan_nxt       = scan_r;
    res_nxt        = res_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = IDX_HEAD;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = cur_r;
    wr_rec         = cur_rec_r;
    slot_wr_en     = 1'b0;
    slot_wr_val    = 1'b0;
    slot_wr_idx    = scan_r;
    res_valid      = 1'b0;
    merge_rec      = rd_rec;
    merge_idx      = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          size_nxt     = req.size;
          offset_nxt   = req.offset;
          cur_nxt      = IDX_HEAD;
          steps_nxt    = '0;
          has_prev_nxt = 1'b0;
          if (req.op == OP_ALLOC) begin
            ram_rd_en = 1'b1;
            state_nxt = S_A_WALK;
          end else if (req.offset == '0) begin
            res_nxt   = '{payload: '0, status: ST_NULL};
            state_nxt = S_DONE;
          end else begin
            ram_rd_en = 1'b1;
            state_nxt = S_R_FIND;
          end
        end
      end

      S_A_WALK: begin
        if (fit) begin
          cur_rec_nxt = rd_rec;
          if (split_need) begin
            scan_nxt  = IDX_ONE;
            state_nxt = S_A_SCAN;
          end else begin
            ram_wr_en   = 1'b1;
            wr_rec      = rd_rec;
            wr_rec.free = 1'b0;
            res_nxt     = '{payload: rd_rec.start + HDR, status: ST_OK};
            state_nxt   = S_DONE;
          end
        end else if (walk_end) begin
          res_nxt   = '{payload: '0, status: ST_NOFIT};
          state_nxt = S_DONE;
        end else begin
          cur_nxt     = rd_rec.link;
          steps_nxt   = steps_r + IDX_ONE;
          ram_rd_en   = 1'b1;
          ram_rd_addr = rd_rec.link;
        end
      end

      S_A_SCAN: begin
        if (!slot_rd_bit) begin
          state_nxt = S_A_SPLIT;
        end else if (scan_r == IDX_LAST) begin
          // table full: hand out the whole segment
          ram_wr_en   = 1'b1;
          wr_rec.free = 1'b0;
          res_nxt     = '{payload: cur_rec_r.start + HDR, status: ST_OK};
          state_nxt   = S_DONE;
        end else begin
          scan_nxt = scan_r + IDX_ONE;
        end
      end

      S_A_SPLIT: begin
        // remainder becomes a new free segment in the spare slot
        ram_wr_en   = 1'b1;
        ram_wr_addr = scan_r;
        wr_rec      = '{
          start: cur_rec_r.start + HDR + size_r,
          bytes: cur_rec_r.bytes - size_r - HDR,
          free:  1'b1,
          link:  cur_rec_r.link
        };
        slot_wr_en  = 1'b1;
        slot_wr_val = 1'b1;
        state_nxt   = S_A_SPLIT2;
      end

      S_A_SPLIT2: begin
        ram_wr_en = 1'b1;
        wr_rec    = '{start: cur_rec_r.start, bytes: size_r, free: 1'b0, link: scan_r};
        res_nxt   = '{payload: cur_rec_r.start + HDR, status: ST_OK};
        state_nxt = S_DONE;
      end

      S_R_FIND: begin
        if (hit) begin
          // mark free, fold into a free predecessor
          if (has_prev_r && prev_rec_r.free) begin
            merge_rec       = prev_rec_r;
            merge_rec.bytes = prev_rec_r.bytes + HDR + rd_rec.bytes;
            merge_rec.link  = rd_rec.link;
            merge_idx       = prev_r;
            slot_wr_en      = 1'b1;
            slot_wr_val     = 1'b0;
            slot_wr_idx     = cur_r;
          end else begin
            merge_rec.free  = 1'b1;
          end
          cur_nxt     = merge_idx;
          cur_rec_nxt = merge_rec;
          if (merge_rec.link == IDX_HEAD) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = merge_idx;
            wr_rec      = merge_rec;
            res_nxt     = '{payload: '0, status: ST_OK};
            state_nxt   = S_DONE;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = merge_rec.link;
            state_nxt   = S_R_MERGE;
          end
        end else if (walk_end) begin
          res_nxt   = '{payload: '0, status: ST_UNKNOWN};
          state_nxt = S_DONE;
        end else begin
          prev_nxt     = cur_r;
          prev_rec_nxt = rd_rec;
          has_prev_nxt = 1'b1;
          cur_nxt      = rd_rec.link;
          steps_nxt    = steps_r + IDX_ONE;
          ram_rd_en    = 1'b1;
          ram_rd_addr  = rd_rec.link;
        end
      end

      S_R_MERGE: begin
        // absorb free successors one at a time
        if (rd_rec.free) begin
          merge_rec       = cur_rec_r;
          merge_rec.bytes = cur_rec_r.bytes + HDR + rd_rec.bytes;
          merge_rec.link  = rd_rec.link;
          slot_wr_en      = 1'b1;
          slot_wr_val     = 1'b0;
          slot_wr_idx     = cur_rec_r.link;
          cur_rec_nxt     = merge_rec;
          if (rd_rec.link == IDX_HEAD) begin
            ram_wr_en = 1'b1;
            wr_rec    = merge_rec;
            res_nxt   = '{payload: '0, status: ST_OK};
            state_nxt = S_DONE;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rd_rec.link;
          end
        end else begin
          ram_wr_en = 1'b1;
          res_nxt   = '{payload: '0, status: ST_OK};
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // head override tracking
  always_comb begin
    head_fresh_nxt = head_fresh_r;
    rd_fresh_nxt   = rd_fresh_r;
    if (ram_wr_en && (ram_wr_addr == IDX_HEAD)) begin
      head_fresh_nxt = 1'b0;
    end
    if (ram_rd_en) begin
      rd_fresh_nxt = head_fresh_r && (ram_rd_addr == IDX_HEAD);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_fresh_r <= 1'b1;
      rd_fresh_r   <= 1'b0;
      has_prev_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_fresh_r <= head_fresh_nxt;
      rd_fresh_r   <= rd_fresh_nxt;
      has_prev_r   <= has_prev_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    offset_r   <= offset_nxt;
    cur_r      <= cur_nxt;
    cur_rec_r  <= cur_rec_nxt;
    prev_r     <= prev_nxt;
    prev_rec_r <= prev_rec_nxt;
    steps_r    <= steps_nxt;
    scan_r     <= scan_nxt;
    res_r      <= res_nxt;
  end

endmodule

FILE: rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator. The heap of HEAP_BYTES bytes is kept as an
// address-ordered list of segments in a table of MAX_SEGMENTS entries held in
// one synchronous RAM; after reset it is a single free segment. An allocate
// request (in_tuser = 0) takes the first free segment that is large enough,
// splitting off the remainder into a new free segment when it exceeds
// HEADER_BYTES + MIN_SPLIT_BYTES and a table slot is spare, and returns the
// payload offset (segment start + HEADER_BYTES) with status 0, or offset 0
// with status 1 when nothing fits. A release (in_tuser = 1) frees the segment
// whose payload offset matches and merges it with a free predecessor and all
// free successors; offset 0 gives status 2 and an unknown offset status 3,
// both leaving the heap untouched. One request is in work at a time. The
// walk reads one list entry per cycle through the RAM's single read port;
// an allocate walks the list to the first segment that fits and, when it
// splits, scans the slot map for a spare slot and writes the remainder and
// then the allocated segment; a release walks to the matching segment and
// merges free successors one at a time, with a last write when the merge
// stops at a successor still in use; a null release reads no entry. The
// result sits in an output register, so the next request is taken while it waits.
module first_fit_heap_allocator_top
  import ffa_pkg::*;
#(
  parameter int unsigned HEAP_BYTES      = 65536,
  parameter int unsigned HEADER_BYTES    = 12,
  parameter int unsigned MIN_SPLIT_BYTES = 16,
  parameter int unsigned MAX_SEGMENTS    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // [15:0] request_size, [31:16] release_offset
  input  logic        in_tuser,  // [0] operation
  // result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // [15:0] payload_offset
  output logic [1:0]  out_tuser  // [1:0] status
);

  localparam int unsigned LINK_W = $clog2(MAX_SEGMENTS);
  localparam int unsigned REC_W  = 2 * DATA_W + 1 + LINK_W;

  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              ram_wr_en;
  logic [LINK_W-1:0] ram_wr_addr;
  logic [REC_W-1:0]  ram_wr_data;
  logic              ram_rd_en;
  logic [LINK_W-1:0] ram_rd_addr;
  logic [REC_W-1:0]  ram_rd_data;
  logic              slot_wr_en;
  logic              slot_wr_val;
  logic [LINK_W-1:0] slot_wr_idx;
  logic [LINK_W-1:0] slot_rd_idx;
  logic              slot_rd_bit;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  // unpack the input transaction
  assign req = '{op: op_t'(in_tuser), size: in_tdata[15:0], offset: in_tdata[31:16]};

  ffa_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ffa_slot_map #(
    .SLOTS (MAX_SEGMENTS)
  ) u_slot_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (slot_wr_en),
    .wr_val (slot_wr_val),
    .wr_idx (slot_wr_idx),
    .rd_idx (slot_rd_idx),
    .rd_bit (slot_rd_bit)
  );

  ffa_engine #(
    .HEAP_BYTES      (HEAP_BYTES),
    .HEADER_BYTES    (HEADER_BYTES),
    .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES),
    .MAX_SEGMENTS    (MAX_SEGMENTS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .slot_wr_en  (slot_wr_en),
    .slot_wr_val (slot_wr_val),
    .slot_wr_idx (slot_wr_idx),
    .slot_rd_idx (slot_rd_idx),
    .slot_rd_bit (slot_rd_bit)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.payload;
  assign out_tuser  = out_res_r.status;

endmodule
